// ===== hw/rtl/bls_pkg.sv =====
// Shared types and command codes for the Bresenham line stepper.
package bls_pkg;

    localparam int COLOR_BITS = 16;

    typedef logic                  func_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    localparam func_t FUNC_START = 1'b0;
    localparam func_t FUNC_NEXT  = 1'b1;

endpackage

// ===== hw/rtl/bls_cmd_if.sv =====
// Command channel: start items with endpoints and colour, or next-pixel requests.
interface bls_cmd_if
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    func_t                        func;
    logic signed [COORD_BITS-1:0] x_first;
    logic signed [COORD_BITS-1:0] y_first;
    logic signed [COORD_BITS-1:0] x_second;
    logic signed [COORD_BITS-1:0] y_second;
    color_t                       color;

    modport source (
        output valid, func, x_first, y_first, x_second, y_second, color,
        input  ready
    );

    modport sink (
        input  valid, func, x_first, y_first, x_second, y_second, color,
        output ready
    );
endinterface

// ===== hw/rtl/bls_pix_if.sv =====
// Pixel channel: one rasterised pixel per item.
interface bls_pix_if
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    color_t                       pixel_color;
    logic                         last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

// ===== hw/rtl/bresenham_line_stepper.sv =====
// Bresenham line stepper: an accepted next item's pixel is in the output register in the
// following cycle; throughput one item per cycle while the sink takes each pixel, set by the single
// add-and-compare error step between the line state and the pixel register.
// A waiting pixel holds the input until the sink takes it; a new item enters in that cycle.
// A start item yields no pixel. Reset (rst_n low, asynchronous)
// clears all line state, so no line is active and the output is empty.
module bresenham_line_stepper
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 16
)(
    input  logic      clk,
    input  logic      rst_n,
    bls_cmd_if.sink   cmd,
    bls_pix_if.source pixel
);

    localparam int W = COORD_BITS;

    typedef logic signed [W-1:0] coord_t;
    typedef logic        [W:0]   delta_t;
    typedef logic        [W+1:0] sum_t;

    // line state
    logic   active_reg,       active_next;
    logic   stop_pending_reg, stop_pending_next;
    coord_t cur_x_reg,        cur_x_next;
    coord_t cur_y_reg,        cur_y_next;
    coord_t end_x_reg,        end_x_next;
    coord_t end_y_reg,        end_y_next;
    delta_t delta_major_reg,  delta_major_next;
    delta_t delta_minor_reg,  delta_minor_next;
    delta_t error_acc_reg,    error_acc_next;
    delta_t steps_left_reg,   steps_left_next;
    logic   y_major_reg,      y_major_next;
    logic   y_down_reg,       y_down_next;
    color_t line_color_reg,   line_color_next;

    // output register
    logic   out_valid_reg,    out_valid_next;
    coord_t pixel_x_reg,      pixel_x_next;
    coord_t pixel_y_reg,      pixel_y_next;
    color_t pixel_color_reg,  pixel_color_next;
    logic   last_pixel_reg,   last_pixel_next;

    logic   cmd_fire;
    logic   pix_take;
    logic   emit;

    // start set-up
    logic   first_is_start;
    coord_t sx, sy, ex, ey;
    delta_t dx, dy, dy_diff;
    logic   dn, ymaj;

    // walk step
    sum_t   err_sum;
    logic   minor_step;
    coord_t y_stepped;

    assign cmd.ready = !out_valid_reg || pixel.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign pix_take  = out_valid_reg && pixel.ready;
    assign emit      = cmd_fire && (cmd.func == FUNC_NEXT) && active_reg;

    assign pixel.valid       = out_valid_reg;
    assign pixel.pixel_x     = pixel_x_reg;
    assign pixel.pixel_y     = pixel_y_reg;
    assign pixel.pixel_color = pixel_color_reg;
    assign pixel.last_pixel  = last_pixel_reg;

    // order the endpoints so x never decreases; on equal x the second one starts
    always_comb
    begin
        first_is_start = cmd.x_second > cmd.x_first;
        sx = first_is_start ? cmd.x_first  : cmd.x_second;
        sy = first_is_start ? cmd.y_first  : cmd.y_second;
        ex = first_is_start ? cmd.x_second : cmd.x_first;
        ey = first_is_start ? cmd.y_second : cmd.y_first;
        dx      = {ex[W-1], ex} - {sx[W-1], sx};
        dn      = ey < sy;
        dy_diff = {ey[W-1], ey} - {sy[W-1], sy};
        dy      = dn ? (~dy_diff + delta_t'(1)) : dy_diff;
        ymaj    = dy > dx;
    end

    always_comb
    begin
        err_sum    = {1'b0, error_acc_reg} + {1'b0, delta_minor_reg};
        minor_step = err_sum >= {1'b0, delta_major_reg};
        y_stepped  = y_down_reg ? (cur_y_reg - coord_t'(1)) : (cur_y_reg + coord_t'(1));
    end

    always_comb
    begin
        active_next       = active_reg;
        stop_pending_next = stop_pending_reg;
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        end_x_next        = end_x_reg;
        end_y_next        = end_y_reg;
        delta_major_next  = delta_major_reg;
        delta_minor_next  = delta_minor_reg;
        error_acc_next    = error_acc_reg;
        steps_left_next   = steps_left_reg;
        y_major_next      = y_major_reg;
        y_down_next       = y_down_reg;
        line_color_next   = line_color_reg;

        out_valid_next    = pix_take ? 1'b0 : out_valid_reg;
        pixel_x_next      = pixel_x_reg;
        pixel_y_next      = pixel_y_reg;
        pixel_color_next  = pixel_color_reg;
        last_pixel_next   = last_pixel_reg;

        if (cmd_fire && (cmd.func == FUNC_START))
        begin
            // latch a new line, replacing any line in progress
            end_x_next        = ex;
            end_y_next        = ey;
            cur_x_next        = sx;
            cur_y_next        = sy;
            y_down_next       = dn;
            y_major_next      = ymaj;
            delta_major_next  = ymaj ? dy : dx;
            delta_minor_next  = ymaj ? dx : dy;
            error_acc_next    = (ymaj ? dy : dx) >> 1;
            steps_left_next   = ymaj ? dy : dx;
            line_color_next   = cmd.color;
            active_next       = 1'b1;
            stop_pending_next = 1'b1;
        end
        else if (emit)
        begin
            out_valid_next   = 1'b1;
            pixel_color_next = line_color_reg;
            if (stop_pending_reg)
            begin
                // stop endpoint goes out first
                pixel_x_next      = end_x_reg;
                pixel_y_next      = end_y_reg;
                last_pixel_next   = (steps_left_reg == '0);
                stop_pending_next = 1'b0;
                if (steps_left_reg == '0)
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                pixel_x_next    = cur_x_reg;
                pixel_y_next    = cur_y_reg;
                last_pixel_next = (steps_left_reg == delta_t'(1));
                steps_left_next = steps_left_reg - delta_t'(1);
                if (steps_left_reg == delta_t'(1))
                begin
                    active_next = 1'b0;
                end
                // advance the major axis, and the minor one when the error wraps
                if (y_major_reg)
                begin
                    cur_y_next = y_stepped;
                    cur_x_next = minor_step ? (cur_x_reg + coord_t'(1)) : cur_x_reg;
                end
                else
                begin
                    cur_x_next = cur_x_reg + coord_t'(1);
                    cur_y_next = minor_step ? y_stepped : cur_y_reg;
                end
                error_acc_next = minor_step
                               ? delta_t'(err_sum - {1'b0, delta_major_reg})
                               : delta_t'(err_sum);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            stop_pending_reg <= 1'b0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            end_x_reg        <= '0;
            end_y_reg        <= '0;
            delta_major_reg  <= '0;
            delta_minor_reg  <= '0;
            error_acc_reg    <= '0;
            steps_left_reg   <= '0;
            y_major_reg      <= 1'b0;
            y_down_reg       <= 1'b0;
            line_color_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            active_reg       <= active_next;
            stop_pending_reg <= stop_pending_next;
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            end_x_reg        <= end_x_next;
            end_y_reg        <= end_y_next;
            delta_major_reg  <= delta_major_next;
            delta_minor_reg  <= delta_minor_next;
            error_acc_reg    <= error_acc_next;
            steps_left_reg   <= steps_left_next;
            y_major_reg      <= y_major_next;
            y_down_reg       <= y_down_next;
            line_color_reg   <= line_color_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg     <= pixel_x_next;
        pixel_y_reg     <= pixel_y_next;
        pixel_color_reg <= pixel_color_next;
        last_pixel_reg  <= last_pixel_next;
    end

    // a pixel only appears after an accepted next item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.valid && cmd.ready && (cmd.func == FUNC_NEXT)))
        else $error("pixel appeared without a next item");

    assert property (@(posedge clk) disable iff (!rst_n)
        stop_pending_reg |-> active_reg)
        else $error("stop pixel pending on an inactive line");

    // while walking, the error term stays below the major delta
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && (delta_major_reg != '0)) |-> (error_acc_reg < delta_major_reg))
        else $error("error accumulator out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !stop_pending_reg) |-> (steps_left_reg != '0))
        else $error("active walk with no steps left");

    // a pixel waiting on a stalled sink must not be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pixel.ready) |=> $stable(pixel_x_reg) && $stable(pixel_y_reg))
        else $error("stalled pixel overwritten");

endmodule
